[rtl/ddcfc_pkg.sv]
// Package for the DDC/CI reply frame checker.
// Holds the field widths, frame constants, status codes, register indices and phase type.
// No dependencies.
`default_nettype none

package ddcfc_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ADDR_W   = 7;
	localparam int unsigned LEN_W    = 7;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CFG_W    = 7;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [BYTE_W-1:0] XOR_SEED  = 8'h50;
	localparam logic [BYTE_W-1:0] BUSY_MARK = 8'h51;
	localparam logic [BYTE_W-1:0] BUSY_FF   = 8'hFF;

	// Configuration register indices
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD    = 1'd1;

	localparam logic [ADDR_W-1:0] DEVICE_ADDRESS_RST = 7'd55;
	localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST    = 7'd32;

	typedef enum logic [STATUS_W-1:0] {
		ST_PENDING = 3'd0,
		ST_OK      = 3'd1,
		ST_BUSY    = 3'd2,
		ST_BADADDR = 3'd3,
		ST_NOFLAG  = 3'd4,
		ST_TOOLONG = 3'd5,
		ST_BADXOR  = 3'd6
	} status_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_LENGTH  = 5'b00010,
		PH_PAYLOAD = 5'b00100,
		PH_CHECK   = 5'b01000,
		PH_DONE    = 5'b10000
	} phase_t;

endpackage

`default_nettype wire

[rtl/ddc_ci_frame_checker_top.sv]
// Top level of the DDC/CI reply frame checker.
// Depends on ddcfc_pkg for widths, status codes and the phase type.
`default_nettype none

// Checks a DDC/CI reply one received byte per beat and gives exactly one
// result beat for every input beat. A byte is captured in an input register,
// the frame state (phase, bytes left, running XOR, length) is updated from it
// and the result is registered in an output register along with the new frame
// state. The block sustains one byte per cycle while the output is not stalled.
// The input side keeps accepting while a result waits on a stalled output, as
// long as the input register is empty. Payload bytes are forwarded as they
// arrive; keep them only if the frame ends with status ok. Configuration writes
// are taken at any time but must only be made while no byte is in flight.
module ddc_ci_frame_checker_top (
	input  wire                               clk,
	input  wire                               arst_n,
	// configuration
	input  wire                               cfg_wr_en,
	input  wire  [ddcfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [ddcfc_pkg::CFG_W-1:0]       cfg_data,
	// input channel
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire  [ddcfc_pkg::BYTE_W-1:0]      rx_byte,
	input  wire                               frame_start,
	// result channel
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [ddcfc_pkg::BYTE_W-1:0]      payload_byte,
	output logic                              payload_valid,
	output logic                              frame_end,
	output logic [ddcfc_pkg::STATUS_W-1:0]    status,
	output logic [ddcfc_pkg::LEN_W-1:0]       frame_length
);

	// configuration registers
	logic [ddcfc_pkg::ADDR_W-1:0] device_address_q;
	logic [ddcfc_pkg::LEN_W-1:0]  max_payload_q;

	// input register
	logic                         valid_s1;
	logic [ddcfc_pkg::BYTE_W-1:0] byte_s1;
	logic                         start_s1;

	// frame state
	ddcfc_pkg::phase_t            phase_q;
	logic [ddcfc_pkg::LEN_W-1:0]  bytes_left_q;
	logic [ddcfc_pkg::BYTE_W-1:0] xor_q;
	logic [ddcfc_pkg::LEN_W-1:0]  length_q;

	// result register
	logic                         valid_s2;
	logic [ddcfc_pkg::BYTE_W-1:0] pbyte_s2;
	logic                         pvalid_s2;
	logic                         fend_s2;
	ddcfc_pkg::status_t           status_s2;
	logic [ddcfc_pkg::LEN_W-1:0]  length_s2;

	// next-state values
	ddcfc_pkg::phase_t            phase_d;
	logic [ddcfc_pkg::LEN_W-1:0]  bytes_left_d;
	logic [ddcfc_pkg::BYTE_W-1:0] xor_d;
	logic [ddcfc_pkg::LEN_W-1:0]  length_d;
	logic [ddcfc_pkg::BYTE_W-1:0] pbyte_d;
	logic                         pvalid_d;
	logic                         fend_d;
	ddcfc_pkg::status_t           status_d;
	logic [ddcfc_pkg::BYTE_W-1:0] xor_chk;
	logic [ddcfc_pkg::LEN_W-1:0]  len_field;

	logic advance;
	logic in_take;

	// pipeline moves whenever the result register is empty or being taken
	assign advance  = !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= ddcfc_pkg::DEVICE_ADDRESS_RST;
			max_payload_q    <= ddcfc_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ddcfc_pkg::REG_DEVICE_ADDRESS: device_address_q <= cfg_data;
				ddcfc_pkg::REG_MAX_PAYLOAD:    max_payload_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	// frame parser: next state and result for the byte in the input register
	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		xor_d        = xor_q;
		length_d     = length_q;
		pbyte_d      = '0;
		pvalid_d     = 1'b0;
		fend_d       = 1'b0;
		status_d     = ddcfc_pkg::ST_PENDING;
		xor_chk      = xor_q ^ byte_s1;
		len_field    = byte_s1[ddcfc_pkg::LEN_W-1:0];

		if (start_s1) begin
			xor_d        = ddcfc_pkg::XOR_SEED;
			bytes_left_d = '0;
			length_d     = '0;
			fend_d       = 1'b1;
			phase_d      = ddcfc_pkg::PH_DONE;
			if (byte_s1 == ddcfc_pkg::BUSY_MARK || byte_s1 == ddcfc_pkg::BUSY_FF) begin
				status_d = ddcfc_pkg::ST_BUSY;
			end else if (byte_s1 != {device_address_q, 1'b0}) begin
				status_d = ddcfc_pkg::ST_BADADDR;
			end else begin
				fend_d  = 1'b0;
				xor_d   = ddcfc_pkg::XOR_SEED ^ byte_s1;
				phase_d = ddcfc_pkg::PH_LENGTH;
			end
		end else begin
			case (phase_q)
				ddcfc_pkg::PH_LENGTH: begin
					if (!byte_s1[ddcfc_pkg::BYTE_W-1]) begin
						length_d = '0;
						status_d = ddcfc_pkg::ST_NOFLAG;
						fend_d   = 1'b1;
						phase_d  = ddcfc_pkg::PH_DONE;
					end else if (len_field > max_payload_q) begin
						length_d = len_field;
						status_d = ddcfc_pkg::ST_TOOLONG;
						fend_d   = 1'b1;
						phase_d  = ddcfc_pkg::PH_DONE;
					end else begin
						length_d     = len_field;
						xor_d        = xor_chk;
						bytes_left_d = len_field;
						phase_d      = (len_field != '0) ? ddcfc_pkg::PH_PAYLOAD
						                                 : ddcfc_pkg::PH_CHECK;
					end
				end
				ddcfc_pkg::PH_PAYLOAD: begin
					xor_d        = xor_chk;
					pbyte_d      = byte_s1;
					pvalid_d     = 1'b1;
					bytes_left_d = bytes_left_q - 1'b1;
					if (bytes_left_q == 7'd1) begin
						phase_d = ddcfc_pkg::PH_CHECK;
					end
				end
				ddcfc_pkg::PH_CHECK: begin
					xor_d    = xor_chk;
					status_d = (xor_chk == '0) ? ddcfc_pkg::ST_OK : ddcfc_pkg::ST_BADXOR;
					fend_d   = 1'b1;
					phase_d  = ddcfc_pkg::PH_DONE;
				end
				default: ;
			endcase
		end
	end

	// frame state update, one byte per cycle while the output is not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= ddcfc_pkg::PH_IDLE;
			bytes_left_q <= '0;
			xor_q        <= ddcfc_pkg::XOR_SEED;
			length_q     <= '0;
		end else if (valid_s1 && advance) begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			xor_q        <= xor_d;
			length_q     <= length_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			pbyte_s2  <= pbyte_d;
			pvalid_s2 <= pvalid_d;
			fend_s2   <= fend_d;
			status_s2 <= status_d;
			length_s2 <= length_d;
		end
	end

	assign out_valid     = valid_s2;
	assign payload_byte  = pbyte_s2;
	assign payload_valid = pvalid_s2;
	assign frame_end     = fend_s2;
	assign status        = status_s2;
	assign frame_length  = length_s2;

	// a final status only comes with the end of a frame
	a_status_with_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2 != ddcfc_pkg::ST_PENDING) |-> fend_s2)
		else $error("status reported without frame end");

	// a payload beat never ends a frame
	a_payload_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && pvalid_s2) |-> (!fend_s2 && status_s2 == ddcfc_pkg::ST_PENDING))
		else $error("payload beat carries frame end");

	// while payload is expected the count is never zero
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ddcfc_pkg::PH_PAYLOAD) |-> (bytes_left_q != '0))
		else $error("payload phase with no bytes left");

	// an empty input register never holds off the sender
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty input register");

	// an ok frame always leaves a zero running XOR behind
	a_ok_xor: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && status_d == ddcfc_pkg::ST_OK) |=> (xor_q == '0))
		else $error("ok status with nonzero check XOR");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for ddc_ci_frame_checker_top: directed and random reply frames
// are scored beat by beat against a behavioural frame parser held in the bench.
// Depends on ddcfc_pkg and the RTL of ddc_ci_frame_checker_top.
`default_nettype none

module testbench;

	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [ddcfc_pkg::BYTE_W-1:0] data;
		logic                         start;
	} rx_beat_t;

	typedef struct {
		logic [ddcfc_pkg::BYTE_W-1:0] pbyte;
		logic                         pvalid;
		logic                         fend;
		ddcfc_pkg::status_t           st;
		logic [ddcfc_pkg::LEN_W-1:0]  flen;
	} reply_t;

	// clock, reset and block ports
	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wr_en = 1'b0;
	logic [ddcfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ddcfc_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [ddcfc_pkg::BYTE_W-1:0]    rx_byte = '0;
	logic                            frame_start = 1'b0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [ddcfc_pkg::BYTE_W-1:0]    payload_byte;
	logic                            payload_valid;
	logic                            frame_end;
	logic [ddcfc_pkg::STATUS_W-1:0]  status;
	logic [ddcfc_pkg::LEN_W-1:0]     frame_length;

	// parser state and register copies
	logic [ddcfc_pkg::ADDR_W-1:0] cur_addr = ddcfc_pkg::DEVICE_ADDRESS_RST;
	logic [ddcfc_pkg::LEN_W-1:0]  cur_maxp = ddcfc_pkg::MAX_PAYLOAD_RST;
	ddcfc_pkg::phase_t            frame_ph = ddcfc_pkg::PH_IDLE;
	logic [ddcfc_pkg::LEN_W-1:0]  bytes_due = '0;
	logic [ddcfc_pkg::BYTE_W-1:0] xor_acc = ddcfc_pkg::XOR_SEED;
	logic [ddcfc_pkg::LEN_W-1:0]  len_seen = '0;

	// bench bookkeeping
	rx_beat_t rx_pending[$];
	reply_t   expected_replies[$];
	rx_beat_t next_beat;
	reply_t   want;
	int       send_idle = 7;
	int       recv_idle = 52;
	int       queued = 0;
	int       replies_seen = 0;
	int       fault_count = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;
	int       quiet = 0;

	ddc_ci_frame_checker_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.frame_start   (frame_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.payload_valid (payload_valid),
		.frame_end     (frame_end),
		.status        (status),
		.frame_length  (frame_length)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advance the frame parser by one received byte and give the reply beat
	function automatic reply_t reply_for_byte(logic [ddcfc_pkg::BYTE_W-1:0] b, logic start);
		reply_t r;
		r.pbyte  = '0;
		r.pvalid = 1'b0;
		r.fend   = 1'b0;
		r.st     = ddcfc_pkg::ST_PENDING;
		if (start) begin
			xor_acc   = ddcfc_pkg::XOR_SEED;
			bytes_due = '0;
			len_seen  = '0;
			r.fend    = 1'b1;
			if (b == ddcfc_pkg::BUSY_MARK || b == ddcfc_pkg::BUSY_FF) begin
				r.st     = ddcfc_pkg::ST_BUSY;
				frame_ph = ddcfc_pkg::PH_DONE;
			end else if (b != {cur_addr, 1'b0}) begin
				r.st     = ddcfc_pkg::ST_BADADDR;
				frame_ph = ddcfc_pkg::PH_DONE;
			end else begin
				r.fend   = 1'b0;
				xor_acc  = xor_acc ^ b;
				frame_ph = ddcfc_pkg::PH_LENGTH;
			end
		end else begin
			case (frame_ph)
				ddcfc_pkg::PH_LENGTH: begin
					if (!b[7]) begin
						len_seen = '0;
						r.st     = ddcfc_pkg::ST_NOFLAG;
						r.fend   = 1'b1;
						frame_ph = ddcfc_pkg::PH_DONE;
					end else begin
						len_seen = b[ddcfc_pkg::LEN_W-1:0];
						if (len_seen > cur_maxp) begin
							r.st     = ddcfc_pkg::ST_TOOLONG;
							r.fend   = 1'b1;
							frame_ph = ddcfc_pkg::PH_DONE;
						end else begin
							xor_acc   = xor_acc ^ b;
							bytes_due = len_seen;
							frame_ph  = (bytes_due != 0) ? ddcfc_pkg::PH_PAYLOAD
							                             : ddcfc_pkg::PH_CHECK;
						end
					end
				end
				ddcfc_pkg::PH_PAYLOAD: begin
					xor_acc   = xor_acc ^ b;
					r.pbyte   = b;
					r.pvalid  = 1'b1;
					bytes_due = bytes_due - 1'b1;
					if (bytes_due == 0)
						frame_ph = ddcfc_pkg::PH_CHECK;
				end
				ddcfc_pkg::PH_CHECK: begin
					xor_acc  = xor_acc ^ b;
					r.st     = (xor_acc == 0) ? ddcfc_pkg::ST_OK : ddcfc_pkg::ST_BADXOR;
					r.fend   = 1'b1;
					frame_ph = ddcfc_pkg::PH_DONE;
				end
				default: ;
			endcase
		end
		r.flen = len_seen;
		return r;
	endfunction

	// Sender: offer queued bytes, predict each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			rx_byte     <= '0;
			frame_start <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_replies.push_back(reply_for_byte(rx_byte, frame_start));
			if (!in_valid || !in_stall) begin
				if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
					next_beat = rx_pending.pop_front();
					in_valid    <= 1'b1;
					rx_byte     <= next_beat.data;
					frame_start <= next_beat.start;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: score reply beats and drive the output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				replies_seen++;
				if (expected_replies.size() == 0) begin
					$error("result beat with no byte outstanding");
					fault_count++;
				end else begin
					want = expected_replies.pop_front();
					if (payload_byte !== want.pbyte) begin
						$error("payload_byte: expected %0h, got %0h", want.pbyte, payload_byte);
						fault_count++;
					end
					if (payload_valid !== want.pvalid) begin
						$error("payload_valid: expected %0d, got %0d", want.pvalid,
							payload_valid);
						fault_count++;
					end
					if (frame_end !== want.fend) begin
						$error("frame_end: expected %0d, got %0d", want.fend, frame_end);
						fault_count++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fault_count++;
					end
					if (frame_length !== want.flen) begin
						$error("frame_length: expected %0d, got %0d", want.flen,
							frame_length);
						fault_count++;
					end
				end
			end
			// one long hold-off so the block backs up into its input
			if (!hold_done && replies_seen == 200) begin
				hold_left = 90;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("ddc_ci_frame_checker_top: mismatch");
				$finish;
			end
		end
	end

	task automatic push_byte(logic [ddcfc_pkg::BYTE_W-1:0] b, logic s);
		rx_beat_t t;
		t.data  = b;
		t.start = s;
		rx_pending.push_back(t);
		queued++;
	endtask

	// Reply frame of len payload bytes; bad_chk spoils the check byte,
	// keep cuts it short (0 keeps all of it)
	task automatic add_frame(int len, bit bad_chk, int keep);
		logic [ddcfc_pkg::BYTE_W-1:0] fb[$];
		logic [ddcfc_pkg::BYTE_W-1:0] chk;
		int                           n;
		fb.push_back({cur_addr, 1'b0});
		fb.push_back(8'h80 | len[7:0]);
		for (int i = 0; i < len; i++)
			fb.push_back(8'($urandom_range(255)));
		chk = ddcfc_pkg::XOR_SEED;
		foreach (fb[i])
			chk ^= fb[i];
		if (bad_chk)
			chk ^= 8'($urandom_range(1, 255));
		fb.push_back(chk);
		n = (keep > 0 && keep < fb.size()) ? keep : fb.size();
		for (int i = 0; i < n; i++)
			push_byte(fb[i], i == 0);
	endtask

	function automatic int pick_len();
		int top;
		top = (cur_maxp < 6) ? int'(cur_maxp) : 6;
		if ($urandom_range(39) == 0)
			return int'(cur_maxp);
		return $urandom_range(0, top);
	endfunction

	task automatic add_random_frame();
		int                           kind;
		logic [ddcfc_pkg::BYTE_W-1:0] b;
		kind = $urandom_range(99);
		if (kind < 68) begin
			add_frame(pick_len(), 1'b0, 0);
		end else if (kind < 74) begin
			add_frame(pick_len(), 1'b1, 0);
		end else if (kind < 78) begin
			push_byte($urandom_range(1) ? ddcfc_pkg::BUSY_MARK : ddcfc_pkg::BUSY_FF, 1'b1);
		end else if (kind < 82) begin
			do
				b = 8'($urandom_range(255));
			while (b == {cur_addr, 1'b0} || b == ddcfc_pkg::BUSY_MARK ||
				b == ddcfc_pkg::BUSY_FF);
			push_byte(b, 1'b1);
		end else if (kind < 86) begin
			push_byte({cur_addr, 1'b0}, 1'b1);
			push_byte(8'($urandom_range(127)), 1'b0);
		end else if (kind < 90 && cur_maxp < 127) begin
			push_byte({cur_addr, 1'b0}, 1'b1);
			push_byte(8'h80 | 8'($urandom_range(cur_maxp + 1, 127)), 1'b0);
		end else if (kind < 95) begin
			// frame abandoned part way by the next start
			add_frame(pick_len(), 1'b0, $urandom_range(1, 3));
		end else begin
			// bus noise bytes with no start flag
			repeat ($urandom_range(1, 3))
				push_byte(8'($urandom_range(255)), 1'b0);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (rx_pending.size() != 0 || in_valid || expected_replies.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [ddcfc_pkg::CFG_IDX_W-1:0] idx,
			logic [ddcfc_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == ddcfc_pkg::REG_DEVICE_ADDRESS)
			cur_addr = val;
		else
			cur_maxp = val;
	endtask

	task automatic run_setting(logic [ddcfc_pkg::ADDR_W-1:0] addr,
			logic [ddcfc_pkg::LEN_W-1:0] maxp, int s_idle, int r_idle, int n_bytes);
		int goal;
		wait_drained();
		send_idle = s_idle;
		recv_idle = r_idle;
		write_reg(ddcfc_pkg::REG_DEVICE_ADDRESS, addr);
		write_reg(ddcfc_pkg::REG_MAX_PAYLOAD, maxp);
		goal = queued + n_bytes;
		while (queued < goal)
			add_random_frame();
	endtask

	// Stimulus
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset register values (address byte 6E)
		push_byte(8'h00, 1'b0);              // stray byte while idle
		push_byte(ddcfc_pkg::BUSY_MARK, 1'b1);
		push_byte(ddcfc_pkg::BUSY_FF, 1'b1);
		push_byte(8'h00, 1'b1);              // wrong address
		add_frame(0, 1'b0, 0);               // zero length: check byte follows length
		push_byte(8'hFF, 1'b0);              // ignored after frame end
		push_byte(8'h6E, 1'b1);              // length flag missing
		push_byte(8'h7F, 1'b0);
		push_byte(8'h6E, 1'b1);              // one over max_payload
		push_byte(8'hA1, 1'b0);
		push_byte(8'hAA, 1'b0);              // ignored, length held
		push_byte(8'h6E, 1'b1);              // payload extremes
		push_byte(8'h82, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h50 ^ 8'h6E ^ 8'h82 ^ 8'h00 ^ 8'hFF, 1'b0);
		push_byte(8'h6E, 1'b1);              // dropped by the next start
		push_byte(8'h81, 1'b0);
		add_frame(1, 1'b1, 0);               // bad check byte

		run_setting(7'($urandom_range(1, 126)), 7'($urandom_range(4, 20)), 7, 52, 250);
		run_setting(7'd0, 7'd0, 7, 52, 150);
		run_setting(7'd127, 7'd127, 52, 7, 250);
		run_setting(7'($urandom_range(127)), 7'($urandom_range(1, 10)), 52, 7, 200);
		run_setting(7'($urandom_range(127)), 7'($urandom_range(127)), 0, 0, 250);

		wait_drained();
		repeat (8) @(posedge clk);
		if (fault_count == 0 && expected_replies.size() == 0)
			$display("ddc_ci_frame_checker_top: match");
		else
			$display("ddc_ci_frame_checker_top: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
